// ===== design/qdnr_pkg.sv =====
package qdnr_pkg;

    // Default lane count; each item carries this many weight/activation pairs
    localparam int LANES_DEF = 4;

    // Field widths
    localparam int DATA_W     = 8;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int PROD_W     = DATA_W + DIFF_W;
    localparam int ACC_W      = 32;
    localparam int PRODUCT_W  = 2 * ACC_W;
    localparam int OUT_W      = 7;
    localparam int SHIFT_W    = 6;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [OUT_W-1:0]   OUT_MAX     = 7'd127;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd31;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IN_ZP  = 2'd0,
        CFG_OUT_ZP = 2'd1,
        CFG_SHIFT  = 2'd2
    } cfg_idx_t;

    // Control that travels with an item down the pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } qdnr_ctl_t;

endpackage

// ===== design/qdnr_lane.sv =====
module qdnr_lane (
    input  logic                                     aclk,
    input  logic signed [qdnr_pkg::DATA_W-1:0]       weight,
    input  logic        [qdnr_pkg::DATA_W-1:0]       activation,
    input  logic        [qdnr_pkg::DATA_W-1:0]       in_zp,
    output logic signed [qdnr_pkg::PROD_W-1:0]       prod_reg
);
    import qdnr_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next;

    // Zero-point corrected activation times weight
    assign diff      = $signed({1'b0, activation}) - $signed({1'b0, in_zp});
    assign prod_next = PROD_W'(weight) * PROD_W'(diff);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

// ===== design/qdnr_merge.sv =====
module qdnr_merge #(
    parameter int LANES = qdnr_pkg::LANES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  qdnr_pkg::qdnr_ctl_t                    ctl_in,
    input  logic signed [qdnr_pkg::PROD_W-1:0]     lane_prod [LANES],
    input  logic        [qdnr_pkg::ACC_W-1:0]      bias_in,
    input  logic        [qdnr_pkg::ACC_W-1:0]      mult_in,
    output logic                                   rq_valid,
    output logic        [qdnr_pkg::ACC_W-1:0]      rq_acc,
    output logic        [qdnr_pkg::ACC_W-1:0]      rq_mult
);
    import qdnr_pkg::*;

    localparam int SUM_W = PROD_W + $clog2(LANES);

    qdnr_ctl_t               ctl2_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic [ACC_W-1:0]        bias2_reg;
    logic [ACC_W-1:0]        mult2_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic                    rq_valid_reg;
    logic [ACC_W-1:0]        rq_mult_reg;

    // Reduce the lane products
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < LANES; i++) begin
            sum_next = sum_next + SUM_W'(lane_prod[i]);
        end
    end

    // Stage 2: lane sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl2_reg <= '0;
        end else begin
            ctl2_reg <= ctl_in;
        end
        sum_reg   <= sum_next;
        bias2_reg <= bias_in;
        mult2_reg <= mult_in;
    end

    // Accumulate; first item of a neuron starts from the bias
    assign acc_next = (ctl2_reg.first ? bias2_reg : acc_reg) + ACC_W'(sum_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            rq_valid_reg <= 1'b0;
        end else begin
            if (ctl2_reg.valid) begin
                acc_reg <= acc_next;
            end
            rq_valid_reg <= ctl2_reg.valid && ctl2_reg.last;
        end
        if (ctl2_reg.valid && ctl2_reg.last) begin
            rq_mult_reg <= mult2_reg;
        end
    end

    assign rq_valid = rq_valid_reg;
    assign rq_acc   = acc_reg;
    assign rq_mult  = rq_mult_reg;

endmodule

// ===== design/qdnr_requant.sv =====
module qdnr_requant (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 rq_valid,
    input  logic [qdnr_pkg::ACC_W-1:0]           rq_acc,
    input  logic [qdnr_pkg::ACC_W-1:0]           rq_mult,
    input  logic [qdnr_pkg::SHIFT_W-1:0]         scale_shift,
    input  logic [qdnr_pkg::DATA_W-1:0]          out_zp,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic [qdnr_pkg::OUT_W-1:0]           m_data,
    output logic                                 done
);
    import qdnr_pkg::*;

    logic                 v1_reg;
    logic                 neg1_reg;
    logic [ACC_W-1:0]     mag1_reg;
    logic [ACC_W-1:0]     mult1_reg;
    logic                 v2_reg;
    logic                 neg2_reg;
    logic [PRODUCT_W-1:0] prod2_reg;
    logic [PRODUCT_W-1:0] prod_next;
    logic                 v3_reg;
    logic                 neg3_reg;
    logic [PRODUCT_W-1:0] rnd3_reg;
    logic [PRODUCT_W-1:0] rnd_next;
    logic [PRODUCT_W-1:0] q;
    logic [DATA_W-1:0]    neg_diff;
    logic [DATA_W:0]      pos_sum;
    logic [OUT_W-1:0]     res_next;
    logic                 load;
    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;

    // Q1: sign and magnitude of the accumulator
    // Q2: magnitude times multiplier
    // Q3: add rounding half (away from zero since we work on the magnitude)
    assign prod_next = PRODUCT_W'(mag1_reg) * PRODUCT_W'(mult1_reg);
    assign rnd_next  = (scale_shift == '0) ? prod2_reg
                     : prod2_reg + (PRODUCT_W'(1) << (scale_shift - SHIFT_W'(1)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= rq_valid;
            v2_reg <= v1_reg;
            if (v2_reg) begin
                v3_reg <= 1'b1;
            end else if (load) begin
                v3_reg <= 1'b0;
            end
        end
        if (rq_valid) begin
            neg1_reg  <= rq_acc[ACC_W-1];
            mag1_reg  <= rq_acc[ACC_W-1] ? (ACC_W'(0) - rq_acc) : rq_acc;
            mult1_reg <= rq_mult;
        end
        if (v1_reg) begin
            neg2_reg  <= neg1_reg;
            prod2_reg <= prod_next;
        end
        if (v2_reg) begin
            neg3_reg <= neg2_reg;
            rnd3_reg <= rnd_next;
        end
    end

    // Q4: shift out fraction bits, apply zero point, clamp to 0..127
    assign q        = rnd3_reg >> scale_shift;
    assign neg_diff = out_zp - q[DATA_W-1:0];
    assign pos_sum  = {2'b00, q[OUT_W-1:0]} + {1'b0, out_zp};

    always_comb begin
        if (neg3_reg) begin
            if (q >= PRODUCT_W'(out_zp)) begin
                res_next = '0;
            end else if (neg_diff > DATA_W'(OUT_MAX)) begin
                res_next = OUT_MAX;
            end else begin
                res_next = neg_diff[OUT_W-1:0];
            end
        end else begin
            if (q > PRODUCT_W'(OUT_MAX)) begin
                res_next = OUT_MAX;
            end else if (pos_sum > (DATA_W + 1)'(OUT_MAX)) begin
                res_next = OUT_MAX;
            end else begin
                res_next = pos_sum[OUT_W-1:0];
            end
        end
    end

    // Output register; result waits here while the receiver stalls
    assign load = v3_reg && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (load) begin
            m_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign done    = load;

endmodule

// ===== design/quantized_dense_neuron_requant.sv =====
// One output neuron of an 8-bit quantized dense layer with requantization.
// Input stream (s_): each item carries LANES signed weights, LANES unsigned
// activations, a 32-bit bias and a 32-bit requant multiplier in s_tdata;
// s_tuser marks the first item of a neuron (bias is loaded), s_tlast the
// last (a result is produced). Output stream (m_): one 7-bit value per
// neuron, 0..127. Config writes (cfg_we/cfg_addr/cfg_wdata) set input zero
// point, output zero point and multiplier fraction bits; write only when idle.
// Throughput: items that are not last are taken every cycle unless a last
// item is pending; the lanes, the registered lane sum and the accumulator
// form a 3-stage pipeline. A last item blocks s_tready from its acceptance
// until its result enters the output register, passing the lane, sum,
// accumulate, magnitude, 32x32 multiply, round and clamp stages.
// While the receiver stalls, the result waits in the output register and
// the next neuron's items are still taken up to and including its last
// item; input then stays blocked until that register frees up and the new
// result moves in.
// Reset clears the accumulator to 0, zero points to 0, fraction bits to 31.
module quantized_dense_neuron_requant #(
    parameter int LANES = qdnr_pkg::LANES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_we,
    input  logic [qdnr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [qdnr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // weight_0..weight_N-1, activation_0..activation_N-1, neuron_bias,
    // scale_multiplier
    input  logic [2*LANES*qdnr_pkg::DATA_W + 2*qdnr_pkg::ACC_W-1:0] s_tdata,
    input  logic                                s_tuser,   // first
    input  logic                                s_tlast,   // last
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata    // neuron_output, zero pad
);
    import qdnr_pkg::*;

    localparam int BIAS_LSB = 2 * LANES * DATA_W;
    localparam int MULT_LSB = BIAS_LSB + ACC_W;

    logic [DATA_W-1:0]        in_zp_reg;
    logic [DATA_W-1:0]        out_zp_reg;
    logic [SHIFT_W-1:0]       shift_reg;
    logic                     busy_reg;
    logic                     busy_next;
    logic                     accept;
    qdnr_ctl_t                ctl1_reg;
    logic [ACC_W-1:0]         bias1_reg;
    logic [ACC_W-1:0]         mult1_reg;
    logic signed [PROD_W-1:0] lane_prod [LANES];
    logic                     rq_valid;
    logic [ACC_W-1:0]         rq_acc;
    logic [ACC_W-1:0]         rq_mult;
    logic [OUT_W-1:0]         res_data;
    logic                     done;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_zp_reg  <= '0;
            out_zp_reg <= '0;
            shift_reg  <= SHIFT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_IN_ZP:  in_zp_reg  <= cfg_wdata;
                CFG_OUT_ZP: out_zp_reg <= cfg_wdata;
                CFG_SHIFT:  shift_reg  <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // A last item in flight holds off new items until its result is registered
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !busy_reg;
    assign busy_next = done ? 1'b0 : ((accept && s_tlast) ? 1'b1 : busy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ctl1_reg <= '0;
        end else begin
            busy_reg       <= busy_next;
            ctl1_reg.valid <= accept;
            ctl1_reg.first <= s_tuser;
            ctl1_reg.last  <= s_tlast;
        end
        bias1_reg <= s_tdata[BIAS_LSB +: ACC_W];
        mult1_reg <= s_tdata[MULT_LSB +: ACC_W];
    end

    // Lanes
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        qdnr_lane u_lane (
            .aclk       (aclk),
            .weight     (s_tdata[i*DATA_W +: DATA_W]),
            .activation (s_tdata[(LANES+i)*DATA_W +: DATA_W]),
            .in_zp      (in_zp_reg),
            .prod_reg   (lane_prod[i])
        );
    end

    qdnr_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl1_reg),
        .lane_prod (lane_prod),
        .bias_in   (bias1_reg),
        .mult_in   (mult1_reg),
        .rq_valid  (rq_valid),
        .rq_acc    (rq_acc),
        .rq_mult   (rq_mult)
    );

    qdnr_requant u_requant (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rq_valid    (rq_valid),
        .rq_acc      (rq_acc),
        .rq_mult     (rq_mult),
        .scale_shift (shift_reg),
        .out_zp      (out_zp_reg),
        .m_ready     (m_tready),
        .m_valid     (m_tvalid),
        .m_data      (res_data),
        .done        (done)
    );

    assign m_tdata = {1'b0, res_data};

endmodule

// ===== design/qdnr_checker.sv =====
module qdnr_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                s_tlast,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [7:0]                          m_tdata
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Pad bit of the result stays clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7])
        else $error("result pad bit set");

    // A last item blocks input until its result is registered
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken behind a pending last item");

    // With the output free, the result of a last item comes out of the pipeline valid
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast && !m_tvalid |-> ##7 m_tvalid)
        else $error("result latency wrong");

    // A new result arrives together with input opening up again
    a_rise_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("input still blocked after result");

endmodule

bind quantized_dense_neuron_requant qdnr_checker u_qdnr_checker (.*);

// ===== verif/quantized_dense_neuron_requant_tb.sv =====
`timescale 1ns / 1ps

module quantized_dense_neuron_requant_tb;
    import qdnr_pkg::*;

    localparam int LANES        = LANES_DEF;
    localparam int TDATA_W      = 2 * LANES * DATA_W + 2 * ACC_W;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PCT     = 23;

    // One input item as it travels on s_tdata/s_tuser/s_tlast
    typedef struct packed {
        logic [LANES-1:0][DATA_W-1:0] weight;
        logic [LANES-1:0][DATA_W-1:0] act;
        logic [ACC_W-1:0]             bias;
        logic [ACC_W-1:0]             mult;
        logic                         first;
        logic                         last;
    } neuron_item_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]     cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [TDATA_W-1:0]        s_tdata   = '0;
    logic                      s_tuser   = 1'b0;
    logic                      s_tlast   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [7:0]                m_tdata;

    // Predictor state: register copies and the running neuron sum
    logic [7:0]         in_zp_copy    = 8'd0;
    logic [7:0]         out_zp_copy   = 8'd0;
    logic [SHIFT_W-1:0] shift_copy    = SHIFT_RESET;
    logic [ACC_W-1:0]   neuron_sum    = '0;
    logic [OUT_W-1:0]   expected_outputs[$];

    int src_idle_pct      = IDLE_PCT;
    int sink_idle_pct     = IDLE_PCT;
    int sink_hold_cycles  = 0;
    int fail_count        = 0;
    int items_sent        = 0;
    int outputs_checked   = 0;
    int settings_applied  = 0;
    int cycle_count       = 0;

    quantized_dense_neuron_requant #(
        .LANES(LANES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_outputs.size());
            $display("quantized_dense_neuron_requant verification failed");
            $finish;
        end
    end

    function automatic void report_failure(input string msg);
        if (fail_count < 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
        fail_count++;
    endfunction

    // Signed sum times unsigned fixed-point multiplier, rounded half away from
    // zero, plus output zero point, clamped to 0..127
    function automatic logic [OUT_W-1:0] requantize_sum(input logic [ACC_W-1:0] sum,
                                                        input logic [ACC_W-1:0] mult);
        logic [ACC_W-1:0]     neg_sum;
        logic [PRODUCT_W-1:0] mag;
        logic [PRODUCT_W-1:0] prod;
        logic [PRODUCT_W-1:0] q;
        logic [PRODUCT_W-1:0] zp;
        neg_sum = ~sum + 32'd1;
        mag     = sum[ACC_W-1] ? {32'd0, neg_sum} : {32'd0, sum};
        prod    = mag * {32'd0, mult};
        zp      = {56'd0, out_zp_copy};
        if (shift_copy == '0) begin
            q = prod;
        end else begin
            q = (prod + (64'd1 << (shift_copy - 6'd1))) >> shift_copy;
        end
        if (sum[ACC_W-1]) begin
            if (q >= zp) return '0;
            q = zp - q;
            return (q > 64'd127) ? OUT_MAX : q[OUT_W-1:0];
        end
        if (q > 64'd127) return OUT_MAX;
        q = q + zp;
        return (q > 64'd127) ? OUT_MAX : q[OUT_W-1:0];
    endfunction

    // Advance the neuron sum by one item; a last item queues its output
    function automatic void accumulate_item(input neuron_item_t it);
        logic [ACC_W-1:0] sum;
        int lane;
        int w;
        int d;
        sum = it.first ? it.bias : neuron_sum;
        for (lane = 0; lane < LANES; lane++) begin
            w   = $signed(it.weight[lane]);
            d   = int'(it.act[lane]) - int'(in_zp_copy);
            sum = sum + 32'(w * d);
        end
        neuron_sum = sum;
        if (it.last) begin
            expected_outputs.push_back(requantize_sum(sum, it.mult));
        end
    endfunction

    // Offer one item until taken, then maybe idle
    task automatic send_item(input neuron_item_t it);
        s_tdata  <= {it.mult, it.bias, it.act, it.weight};
        s_tuser  <= it.first;
        s_tlast  <= it.last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accumulate_item(it);
        items_sent++;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_fields(input logic [31:0] w, input logic [31:0] a,
                               input logic [31:0] bias, input logic [31:0] mult,
                               input logic first, input logic last);
        neuron_item_t it;
        it.weight = w;
        it.act    = a;
        it.bias   = bias;
        it.mult   = mult;
        it.first  = first;
        it.last   = last;
        send_item(it);
    endtask

    // Stop offering and wait until every queued output is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Program all three registers while the block is idle
    task automatic apply_settings(input logic [7:0] in_zp, input logic [7:0] out_zp,
                                  input logic [SHIFT_W-1:0] shift);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_IN_ZP;
        cfg_wdata <= in_zp;
        @(posedge aclk);
        cfg_addr  <= CFG_OUT_ZP;
        cfg_wdata <= out_zp;
        @(posedge aclk);
        cfg_addr  <= CFG_SHIFT;
        cfg_wdata <= {2'b00, shift};
        @(posedge aclk);
        cfg_we      <= 1'b0;
        in_zp_copy  = in_zp;
        out_zp_copy = out_zp;
        shift_copy  = shift;
        settings_applied++;
    endtask

    function automatic neuron_item_t random_item();
        neuron_item_t it;
        int lane;
        int pick;
        for (lane = 0; lane < LANES; lane++) begin
            // unused lanes carry weight 0
            it.weight[lane] = ($urandom_range(99) < 20) ? 8'h00 : 8'($urandom);
            it.act[lane]    = 8'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 30) begin
            it.bias = $urandom;
        end else if (pick < 85) begin
            it.bias = $urandom >> $urandom_range(31);
            if ($urandom_range(1) == 1) it.bias = -it.bias;
        end else begin
            case ($urandom_range(3))
                0:       it.bias = 32'h8000_0000;
                1:       it.bias = 32'h7FFF_FFFF;
                2:       it.bias = 32'h0000_0000;
                default: it.bias = 32'hFFFF_FFFF;
            endcase
        end
        // multiplier mostly spread over magnitudes so outputs are not all clamped
        pick = $urandom_range(99);
        if (pick < 25) begin
            it.mult = $urandom;
        end else if (pick < 85) begin
            it.mult = $urandom >> $urandom_range(31);
        end else begin
            case ($urandom_range(3))
                0:       it.mult = 32'h0000_0000;
                1:       it.mult = 32'h0000_0001;
                2:       it.mult = 32'hFFFF_FFFF;
                default: it.mult = 32'h1 << shift_copy[4:0];
            endcase
        end
        it.first = 1'b0;
        it.last  = 1'b0;
        return it;
    endfunction

    // Mostly well-formed neurons; some lack a first item, some carry random flags
    task automatic send_random_neurons(input int n_items);
        neuron_item_t it;
        int sent;
        int len;
        int flavor;
        int i;
        sent = 0;
        while (sent < n_items) begin
            len    = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            flavor = $urandom_range(99);
            for (i = 0; i < len; i++) begin
                it       = random_item();
                it.first = (i == 0);
                it.last  = (i == len - 1);
                if (flavor >= 93) begin
                    it.first = 1'($urandom_range(1));
                    it.last  = ($urandom_range(3) == 0);
                end else if (flavor >= 85) begin
                    it.first = 1'b0;
                end
                send_item(it);
                sent++;
            end
        end
    endtask

    // Result checker and receiver ready
    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outputs.size() == 0) begin
                report_failure($sformatf("unexpected output %0d", m_tdata));
            end else begin
                want = expected_outputs.pop_front();
                outputs_checked++;
                if (m_tdata !== {1'b0, want}) begin
                    report_failure($sformatf("neuron_output mismatch: expected %0d, got %0d",
                                             want, m_tdata));
                end
            end
        end
        if (sink_hold_cycles > 0) begin
            sink_hold_cycles--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Field extremes, wrap, missing first, zero fraction bits, rounding, clamping
    task automatic test_directed_corners();
        // no first seen: lanes add onto the reset accumulator
        send_fields(32'h0000_0001, 32'h0000_0005, 32'd0, 32'h8000_0000, 1'b0, 1'b1);
        send_fields(32'h7F7F_7F7F, 32'hFFFF_FFFF, 32'd100, 32'h0, 1'b1, 1'b1);
        send_fields(32'h8080_8080, 32'hFFFF_FFFF, 32'h1000, 32'h100, 1'b1, 1'b1);
        // accumulator wraps past the largest positive value
        send_fields(32'h7F7F_7F7F, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0);
        send_fields(32'h8000_0080, 32'h00FF_00FF, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // sum is kept after a last item
        send_fields(32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 1'b1);
        send_fields(32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 1'b1, 1'b1);

        // zero fraction bits: exact product
        apply_settings(8'd255, 8'd100, 6'd0);
        send_fields(32'h0, 32'h0, -32'sd3, 32'd10, 1'b1, 1'b1);
        send_fields(32'h0, 32'h0, -32'sd200, 32'd1, 1'b1, 1'b1);
        send_fields(32'h0, 32'h0, 32'd27, 32'd1, 1'b1, 1'b1);
        send_fields(32'h0, 32'h0, 32'd28, 32'd1, 1'b1, 1'b1);
        send_fields(32'h0000_0080, 32'h0, 32'h0, 32'd1, 1'b1, 1'b1);

        // halves round away from zero
        apply_settings(8'd10, 8'd10, 6'd1);
        send_fields(32'h0, 32'h0, 32'd3, 32'd1, 1'b1, 1'b1);
        send_fields(32'h0, 32'h0, -32'sd3, 32'd1, 1'b1, 1'b1);
        send_fields(32'h0, 32'h0, -32'sd1, 32'd1, 1'b1, 1'b1);
        send_fields(32'h0, 32'h0, 32'd1, 32'd1, 1'b1, 1'b1);

        // widest shift, largest output zero point
        apply_settings(8'd128, 8'd255, 6'd63);
        send_fields(32'h7F80_017F, 32'h00FF_80FF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_fields(32'h0, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_fields(32'h0, 32'h0, -32'sd1, 32'd1, 1'b1, 1'b1);
    endtask

    task automatic test_random_settings();
        apply_settings(8'd0, 8'd0, SHIFT_RESET);
        send_random_neurons(180);
        apply_settings(8'd128, 8'd64, 6'd16);
        send_random_neurons(180);
        apply_settings(8'd255, 8'd255, 6'd63);
        send_random_neurons(180);
        apply_settings(8'd0, 8'd0, 6'd0);
        send_random_neurons(180);
        apply_settings(8'($urandom), 8'($urandom), 6'($urandom_range(10, 40)));
        send_random_neurons(180);
    endtask

    // Receiver holds off long enough that the block backs up into its input
    task automatic test_output_backpressure();
        apply_settings(8'($urandom), 8'($urandom_range(0, 40)), 6'd24);
        sink_hold_cycles = 400;
        send_random_neurons(100);
    endtask

    task automatic test_continuous_stream();
        drain_results();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random_neurons(150);
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_random_settings();
        test_output_backpressure();
        test_continuous_stream();
        drain_results();

        $display("sent %0d items, checked %0d neuron outputs under %0d register settings",
                 items_sent, outputs_checked, settings_applied);
        $display("covered wrap, missing first items, rounding, clamping and output stalls");
        if (fail_count == 0 && expected_outputs.size() == 0) begin
            $display("quantized_dense_neuron_requant verification clean");
        end else begin
            $display("%0d failures, %0d outputs missing", fail_count, expected_outputs.size());
            $display("quantized_dense_neuron_requant verification failed");
        end
        $finish;
    end

endmodule
